@@ hw/rtl/ray_box_slab_test_top_assert.svh @@
// Assertion macros used by the checker file of the ray box slab test.
`ifndef RAY_BOX_SLAB_TEST_TOP_ASSERT_SVH
`define RAY_BOX_SLAB_TEST_TOP_ASSERT_SVH

// Checked property with reset gating.
`define RBST_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked property that also holds during reset.
`define RBST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/rbst_pkg.sv @@
// ---------------------------------------------------------------------------
// rbst_pkg
// Types and constants shared by the ray box slab test modules.
// ---------------------------------------------------------------------------
package rbst_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int AXES          = 3;
  localparam int NUM_W         = 34;  // width of a signed plane offset
  localparam int DIV_RW        = 64;  // divider remainder width
  localparam int DIV_QW        = 32;  // quotient bits produced
  localparam int DIV_LAT       = DIV_QW + 2;
  localparam int LANE_LAT      = DIV_LAT + 1;
  localparam int TOP_LAT       = LANE_LAT + 1;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;
  localparam logic [1:0] AXIS_NONE = 2'd3;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic [30:0]        half_x;
    logic [30:0]        half_y;
    logic [30:0]        half_z;
    logic [30:0]        max_distance;
  } in_req_t;

  typedef struct packed {
    logic        hit;
    logic [30:0] distance;
    logic [1:0]  face_axis;
    logic        face_negative;
  } out_res_t;

  typedef struct packed {
    logic is_par;
    logic outside;
    logic dir_pos;
  } lane_flags_t;

  typedef struct packed {
    lane_flags_t        flags;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
  } lane_res_t;

endpackage

@@ hw/rtl/ray_box_slab_test_top.sv @@
// ---------------------------------------------------------------------------
// ray_box_slab_test_top
// Ray against axis-aligned box, slab test in signed fixed point.
// ---------------------------------------------------------------------------
// Fully pipelined: a request is taken in every cycle (busy stays low) and
// its result appears on out_res with out_valid high for one cycle. The
// pipeline is made of the six dividers, three axis lanes with two each,
// which resolve one quotient bit per stage over 32 stages, plus operand,
// saturation, ordering and merge registers. Results cannot be held off by
// the receiver; they must be taken when out_valid is high.
module ray_box_slab_test_top #(
  parameter int FRAC_BITS = rbst_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  rbst_pkg::in_req_t  in_req,
  output logic               out_valid,
  output rbst_pkg::out_res_t out_res
);
  import rbst_pkg::*;

  logic [TOP_LAT-1:0] vld_r;
  logic [TOP_LAT-1:0] vld_nxt;
  logic [30:0]        maxd_r [0:LANE_LAT-1];
  lane_res_t          lane_q [AXES];
  logic               accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  rbst_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
    .clk (clk), .org (in_req.origin_x), .dir (in_req.dir_x),
    .half (in_req.half_x), .res (lane_q[0])
  );

  rbst_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
    .clk (clk), .org (in_req.origin_y), .dir (in_req.dir_y),
    .half (in_req.half_y), .res (lane_q[1])
  );

  rbst_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_z (
    .clk (clk), .org (in_req.origin_z), .dir (in_req.dir_z),
    .half (in_req.half_z), .res (lane_q[2])
  );

  always_ff @(posedge clk) begin
    maxd_r[0] <= in_req.max_distance;
    for (int i = 1; i < LANE_LAT; i++) begin
      maxd_r[i] <= maxd_r[i-1];
    end
  end

  rbst_merge u_merge (
    .clk          (clk),
    .lane_in      (lane_q),
    .max_distance (maxd_r[LANE_LAT-1]),
    .res          (out_res)
  );

  assign vld_nxt = {vld_r[TOP_LAT-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign out_valid = vld_r[TOP_LAT-1];

endmodule

@@ hw/rtl/rbst_div.sv @@
// ---------------------------------------------------------------------------
// rbst_div
// Pipelined saturating divider: (num << FRAC_BITS) / den, truncated toward
// zero and clamped to 32 signed bits. One quotient bit per stage.
// ---------------------------------------------------------------------------
module rbst_div #(
  parameter int FRAC_BITS = rbst_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic signed [rbst_pkg::NUM_W-1:0]  num,
  input  logic signed [31:0]                 den,
  output logic signed [31:0]                 quo
);
  import rbst_pkg::*;

  logic [NUM_W-1:0]  num_mag;
  logic [DIV_RW-1:0] mag_n;
  logic [31:0]       den_mag;
  logic              ovf;

  logic [DIV_RW-1:0] rem_r [0:DIV_QW];
  logic [31:0]       dv_r  [0:DIV_QW];
  logic [31:0]       qb_r  [0:DIV_QW];
  logic              neg_r [0:DIV_QW];
  logic              ovf_r [0:DIV_QW];

  logic signed [31:0] quo_nxt;
  logic signed [31:0] quo_r;

  always_comb begin
    num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    mag_n   = {{(DIV_RW-NUM_W){1'b0}}, num_mag} << FRAC_BITS;
    den_mag = den[31] ? 32'(-den) : 32'(den);
    // A quotient of 2^32 or more saturates whatever its sign.
    ovf     = mag_n >= {den_mag, {(DIV_RW-32){1'b0}}};
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= mag_n;
    dv_r[0]  <= den_mag;
    qb_r[0]  <= '0;
    neg_r[0] <= num[NUM_W-1] ^ den[31];
    ovf_r[0] <= ovf;
  end

  for (genvar i = 0; i < DIV_QW; i++) begin : g_stage
    localparam int K = DIV_QW - 1 - i;
    logic [DIV_RW-1:0] trial;
    logic              ge;
    assign trial = {{(DIV_RW-32){1'b0}}, dv_r[i]} << K;
    assign ge    = rem_r[i] >= trial;
    always_ff @(posedge clk) begin
      rem_r[i+1] <= ge ? rem_r[i] - trial : rem_r[i];
      qb_r[i+1]  <= qb_r[i] | (32'(ge) << K);
      dv_r[i+1]  <= dv_r[i];
      neg_r[i+1] <= neg_r[i];
      ovf_r[i+1] <= ovf_r[i];
    end
  end

  always_comb begin
    if (neg_r[DIV_QW]) begin
      if (ovf_r[DIV_QW] || qb_r[DIV_QW] > 32'h8000_0000) begin
        quo_nxt = 32'sh8000_0000;
      end else begin
        quo_nxt = 32'(-qb_r[DIV_QW]);
      end
    end else begin
      if (ovf_r[DIV_QW] || qb_r[DIV_QW][31]) begin
        quo_nxt = 32'sh7fff_ffff;
      end else begin
        quo_nxt = qb_r[DIV_QW];
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
  end

  assign quo = quo_r;

endmodule

@@ hw/rtl/rbst_lane.sv @@
// ---------------------------------------------------------------------------
// rbst_lane
// One axis of the slab test: both plane crossings, ordered, with the
// parallel-ray flags carried alongside.
// ---------------------------------------------------------------------------
module rbst_lane #(
  parameter int FRAC_BITS = rbst_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic signed [31:0]   org,
  input  logic signed [31:0]   dir,
  input  logic [30:0]          half,
  output rbst_pkg::lane_res_t  res
);
  import rbst_pkg::*;

  logic signed [NUM_W-1:0] org_w;
  logic signed [NUM_W-1:0] half_w;
  logic signed [NUM_W-1:0] num_lo;
  logic signed [NUM_W-1:0] num_hi;
  logic signed [31:0]      t_a;
  logic signed [31:0]      t_b;
  lane_flags_t             flags;
  lane_flags_t             flag_r [0:DIV_LAT-1];
  lane_res_t               res_r;

  always_comb begin
    org_w         = NUM_W'(org);
    half_w        = $signed({{(NUM_W-31){1'b0}}, half});
    num_lo        = -half_w - org_w;
    num_hi        = half_w - org_w;
    flags.is_par  = dir == 32'sd0;
    flags.outside = (org_w < -half_w) || (org_w > half_w);
    flags.dir_pos = !dir[31] && dir != 32'sd0;
  end

  rbst_div #(.FRAC_BITS(FRAC_BITS)) u_div_lo (
    .clk (clk), .num (num_lo), .den (dir), .quo (t_a)
  );

  rbst_div #(.FRAC_BITS(FRAC_BITS)) u_div_hi (
    .clk (clk), .num (num_hi), .den (dir), .quo (t_b)
  );

  always_ff @(posedge clk) begin
    flag_r[0] <= flags;
    for (int i = 1; i < DIV_LAT; i++) begin
      flag_r[i] <= flag_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    res_r.flags <= flag_r[DIV_LAT-1];
    res_r.lo    <= (t_a > t_b) ? t_b : t_a;
    res_r.hi    <= (t_a > t_b) ? t_a : t_b;
  end

  assign res = res_r;

endmodule

@@ hw/rtl/rbst_merge.sv @@
// ---------------------------------------------------------------------------
// rbst_merge
// Combines the three axis intervals into entry, exit and face, and decides
// hit or miss.
// ---------------------------------------------------------------------------
module rbst_merge (
  input  logic                 clk,
  input  rbst_pkg::lane_res_t  lane_in [rbst_pkg::AXES],
  input  logic [30:0]          max_distance,
  output rbst_pkg::out_res_t   res
);
  import rbst_pkg::*;

  logic signed [31:0] entry;
  logic signed [31:0] exit_t;
  logic [1:0]         axis_in;
  logic               have_exit;
  logic               par_miss;
  logic               face_neg;
  logic               miss;
  out_res_t           res_nxt;
  out_res_t           res_r;

  always_comb begin
    entry     = '0;
    exit_t    = '0;
    axis_in   = AXIS_NONE;
    have_exit = 1'b0;
    par_miss  = 1'b0;
    face_neg  = 1'b0;
    for (int a = 0; a < AXES; a++) begin
      if (lane_in[a].flags.is_par) begin
        par_miss = par_miss | lane_in[a].flags.outside;
      end else begin
        // Only a strictly later entry moves the face, so ties keep the earlier axis.
        if (axis_in == AXIS_NONE || lane_in[a].lo > entry) begin
          entry    = lane_in[a].lo;
          axis_in  = 2'(a);
          face_neg = lane_in[a].flags.dir_pos;
        end
        if (!have_exit || lane_in[a].hi < exit_t) begin
          exit_t    = lane_in[a].hi;
          have_exit = 1'b1;
        end
      end
    end
    miss = par_miss || axis_in == AXIS_NONE || entry > exit_t || exit_t < 0 ||
           33'(entry) > $signed({2'b00, max_distance});
    if (miss) begin
      res_nxt = '0;
    end else begin
      res_nxt.hit           = 1'b1;
      res_nxt.distance      = (entry > 0) ? entry[30:0] : 31'd0;
      res_nxt.face_axis     = axis_in;
      res_nxt.face_negative = face_neg;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule

@@ hw/rtl/rbst_checker.sv @@
// ---------------------------------------------------------------------------
// rbst_checker
// Port-level checks on the ray box slab test, bound to the top level.
// ---------------------------------------------------------------------------
`include "ray_box_slab_test_top_assert.svh"

module rbst_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input rbst_pkg::out_res_t out_res
);
  import rbst_pkg::*;

  // Every result comes from an earlier accepted request.
  `RBST_ASSERT(a_lat, clk, rst_n, out_valid |-> $past(start && !busy, TOP_LAT), "result without request")
  // A miss carries all-zero fields.
  `RBST_ASSERT(a_miss_zero, clk, rst_n, (out_valid && !out_res.hit) |-> (out_res.distance == 31'd0 && out_res.face_axis == AXIS_X && !out_res.face_negative), "miss fields not zero")
  `RBST_ASSERT(a_axis, clk, rst_n, out_valid |-> out_res.face_axis != AXIS_NONE, "bad face axis")
  `RBST_ASSERT_ALWAYS(a_busy, clk, !busy, "busy raised")

endmodule

bind ray_box_slab_test_top rbst_checker u_rbst_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_res   (out_res)
);

@@ sim/ray_box_slab_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ray_box_slab_checker
// Watches the request and result channels of the ray box slab test, predicts
// each result from the accepted request and compares it field by field.
// ---------------------------------------------------------------------------
module ray_box_slab_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  rbst_pkg::in_req_t  in_req,
  input  logic               out_valid,
  input  rbst_pkg::out_res_t out_res,
  output int                 fail_count,
  output int                 pending
);
  import rbst_pkg::*;

  out_res_t hits_due[$];

  function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Plane crossing: exact scaled numerator, quotient truncated toward zero.
  function automatic logic signed [63:0] plane_t(input logic signed [63:0] num,
                                                 input logic signed [63:0] d);
    logic signed [63:0] scaled;
    scaled = num * (64'sd1 <<< FRAC_BITS_DEF);
    return clamp32(scaled / d);
  endfunction

  function automatic out_res_t slab_predict(input in_req_t r);
    logic signed [63:0] org[3], dir[3], half[3];
    logic signed [63:0] t_in, t_out, lo, hi, sw;
    int       axis_in;
    logic     got_exit;
    out_res_t res;
    org[0] = r.origin_x;  org[1] = r.origin_y;  org[2] = r.origin_z;
    dir[0] = r.dir_x;     dir[1] = r.dir_y;     dir[2] = r.dir_z;
    half[0] = {33'd0, r.half_x}; half[1] = {33'd0, r.half_y};
    half[2] = {33'd0, r.half_z};
    res = '0;
    t_in = 0; t_out = 0; axis_in = -1; got_exit = 1'b0;
    for (int a = 0; a < AXES; a++) begin
      if (dir[a] == 0) begin
        if (org[a] < -half[a] || org[a] > half[a]) return res;
        continue;
      end
      lo = plane_t(-half[a] - org[a], dir[a]);
      hi = plane_t(half[a] - org[a], dir[a]);
      if (lo > hi) begin
        sw = lo; lo = hi; hi = sw;
      end
      if (axis_in < 0 || lo > t_in) begin
        t_in = lo;
        axis_in = a;
      end
      if (!got_exit || hi < t_out) begin
        t_out = hi;
        got_exit = 1'b1;
      end
    end
    if (axis_in < 0 || t_in > t_out || t_out < 0 ||
        t_in > $signed({33'd0, r.max_distance})) return res;
    res.hit = 1'b1;
    res.distance = (t_in > 0) ? t_in[30:0] : '0;
    res.face_axis = (axis_in == 0) ? AXIS_X : (axis_in == 1) ? AXIS_Y : AXIS_Z;
    res.face_negative = dir[axis_in] > 0;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  initial fail_count = 0;
  assign pending = hits_due.size();

  always @(posedge clk) begin
    out_res_t want;
    if (rst_n && start && !busy) hits_due.push_back(slab_predict(in_req));
    if (rst_n && out_valid) begin
      if (hits_due.size() == 0) begin
        report_mismatch("unexpected result", 32'(out_res.distance), 32'd0);
      end else begin
        want = hits_due.pop_front();
        if (out_res.hit !== want.hit)
          report_mismatch("hit", 32'(out_res.hit), 32'(want.hit));
        if (out_res.distance !== want.distance)
          report_mismatch("distance", 32'(out_res.distance), 32'(want.distance));
        if (out_res.face_axis !== want.face_axis)
          report_mismatch("face_axis", 32'(out_res.face_axis), 32'(want.face_axis));
        if (out_res.face_negative !== want.face_negative)
          report_mismatch("face_negative", 32'(out_res.face_negative),
                          32'(want.face_negative));
      end
    end
  end
endmodule

@@ sim/tb_ray_box_slab_test_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_ray_box_slab_test_top
// Drives directed and random ray/box requests into the slab test pipeline
// and reports the checker's verdict.
// ---------------------------------------------------------------------------
module tb_ray_box_slab_test_top;
  import rbst_pkg::*;

  localparam int RANDOM_REQS = 540;
  localparam int STALL_LIMIT = 2000;

  logic     clk, rst_n, start, busy, out_valid;
  in_req_t  in_req;
  out_res_t out_res;
  int       fail_count, pending;
  int       quiet_cycles;
  int       req_idx;
  logic     calm;

  ray_box_slab_test_top uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req(in_req), .out_valid(out_valid), .out_res(out_res)
  );

  ray_box_slab_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_res(out_res), .fail_count(fail_count),
    .pending(pending)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h0;
      2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return $signed($urandom_range(0, 32'h000a0000)) - 32'sh00050000;
    endcase
  endfunction

  function automatic logic [30:0] rand_span();
    case ($urandom_range(0, 4))
      0: return 31'($urandom());
      1: return $urandom_range(0, 1) ? 31'h7fffffff : 31'h0;
      default: return 31'($urandom_range(0, 32'h00040000));
    endcase
  endfunction

  function automatic in_req_t rand_ray();
    in_req_t r;
    r.origin_x = rand_coord(); r.origin_y = rand_coord(); r.origin_z = rand_coord();
    r.dir_x = rand_coord();    r.dir_y = rand_coord();    r.dir_z = rand_coord();
    r.half_x = rand_span();    r.half_y = rand_span();    r.half_z = rand_span();
    r.max_distance = $urandom_range(0, 3) == 0 ? rand_span()
                                                 : 31'($urandom_range(0, 32'h00200000));
    return r;
  endfunction

  function automatic in_req_t ray(input logic [31:0] ox, oy, oz, dx, dy, dz,
                                  input logic [30:0] h, md);
    in_req_t r;
    r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
    r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
    r.half_x = h; r.half_y = h; r.half_z = h; r.max_distance = md;
    return r;
  endfunction

  in_req_t directed[$];

  // Presents one request and holds it until the block takes it.
  task automatic send_request(input in_req_t r);
    while (!calm && $urandom_range(0, 99) < 22) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start  <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0; start = 1'b0; in_req = '0; quiet_cycles = 0; calm = 1'b0;
    directed.push_back(ray(32'hfffd0000, 0, 0, 32'h00010000, 0, 0, 31'h10000, 31'h7fffffff));
    directed.push_back(ray(32'h00030000, 0, 0, 32'hffff0000, 0, 0, 31'h10000, 31'h7fffffff));
    directed.push_back(ray(0, 32'hfffd0000, 0, 0, 32'h00010000, 0, 31'h10000, 31'h7fffffff));
    directed.push_back(ray(0, 0, 32'h00030000, 0, 0, 32'hffff0000, 31'h10000, 31'h7fffffff));
    directed.push_back(ray(0, 0, 0, 32'h00010000, 32'h00010000, 0, 31'h10000, 31'h10000));
    directed.push_back(ray(0, 0, 0, 0, 0, 0, 31'h10000, 31'h10000));
    directed.push_back(ray(32'h00050000, 0, 0, 0, 32'h00010000, 0, 31'h10000, 31'h7fffffff));
    directed.push_back(ray(32'h00030000, 0, 0, 32'h00010000, 0, 0, 31'h10000, 31'h7fffffff));
    directed.push_back(ray(32'hfffd0000, 0, 0, 32'h00010000, 0, 0, 31'h10000, 31'h10000));
    directed.push_back(ray(32'hfffd0000, 32'h00030000, 0, 32'h00010000, 0, 0, 31'h10000,
                           31'h7fffffff));
    directed.push_back(ray(32'h80000000, 32'h80000000, 32'h80000000, 32'h00000001,
                           32'h00000001, 32'h00000001, 31'h7fffffff, 31'h7fffffff));
    directed.push_back(ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                           32'h80000000, 32'h80000000, 31'h7fffffff, 31'h7fffffff));
    directed.push_back(ray(0, 0, 0, 32'h00000001, 32'hffffffff, 32'h7fffffff, 31'h0, 31'h0));
    directed.push_back(ray(32'hfffe0000, 32'hfffe0000, 32'hfffe0000, 32'h00010000,
                           32'h00010000, 32'h00010000, 31'h10000, 31'h7fffffff));
    directed.push_back(ray(32'hffffffff, 32'h00000001, 0, 32'h7fffffff, 32'h80000000,
                           32'h00010000, 31'h7fffffff, 31'h7fffffff));
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) send_request(directed[i]);
    for (req_idx = 0; req_idx < RANDOM_REQS; req_idx++) begin
      calm = (req_idx >= 200 && req_idx < 300);
      send_request(rand_ray());
    end
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (TOP_LAT + 10) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/rbst_pkg.sv
hw/rtl/rbst_div.sv
hw/rtl/rbst_lane.sv
hw/rtl/rbst_merge.sv
hw/rtl/ray_box_slab_test_top.sv
hw/rtl/rbst_checker.sv
sim/ray_box_slab_checker.sv
sim/tb_ray_box_slab_test_top.sv
